/* design/lphi_pkg.sv */
package lphi_pkg;

   // Field widths of the channels and the size register
   localparam int KEY_W  = 31;
   localparam int SIZE_W = 11;
   localparam int OUT_W  = 10;

   // Reset value of the size register
   localparam int SIZE_RESET = 1024;

   // Remainder unit: dividend padded to DIV_W bits, DIV_BITS bits retired per cycle
   localparam int DIV_W    = 32;
   localparam int DIV_BITS = 4;
   localparam int DIV_CYC  = DIV_W / DIV_BITS;
   localparam int DIV_CW   = $clog2(DIV_CYC);

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [OUT_W-1:0]  out_type;

endpackage

/* design/lphi_if.sv */
interface lphi_req_if;
   import lphi_pkg::*;

   logic    valid;
   logic    ready;
   key_type key;

   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface

interface lphi_rsp_if;
   import lphi_pkg::*;

   logic    valid;
   logic    ready;
   out_type slot_index;
   out_type probe_count;
   logic    table_full;

   modport source (output valid, output slot_index, output probe_count,
                   output table_full, input ready);
   modport sink   (input valid, input slot_index, input probe_count,
                   input table_full, output ready);
endinterface

/* design/linear_probe_hash_insert.sv */
// Channel    Dir  Transfer when        Payload
// req_chan   in   valid && ready       key (31 b)
// rsp_chan   out  valid && ready       slot_index (10 b), probe_count (10 b), table_full
// csr_*      in   csr_wr_en            csr_wr_data: table_size (11 b)
//
// An insert is accepted, passes the remainder unit (4 key bits per cycle), then each
// slot examined is read, then checked, until a result reaches the result register: a
// free slot's index and probe count, or table_full when every slot in use is taken.
// After reset and after every table_size write a clearing pass writes every slot,
// one slot per cycle, during which no key is taken.
// A waiting result never blocks input; the walk holds at its last step until it drains.
module linear_probe_hash_insert #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   lphi_req_if.sink            req_chan,
   lphi_rsp_if.source          rsp_chan,
   input  logic                csr_wr_en,
   input  lphi_pkg::size_type  csr_wr_data
);
   import lphi_pkg::*;

   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int SIZE_RST = (TABLE_DEPTH < SIZE_RESET) ? TABLE_DEPTH : SIZE_RESET;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;

   logic [2:0]       state_ff, state_in;
   size_type         size_ff, size_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   key_type          key_ff, key_in;
   size_type         probe_ff, probe_in;
   size_type         skip_ff, skip_in;

   logic             rsp_valid_ff, rsp_valid_in;
   out_type          rsp_slot_ff, rsp_slot_in;
   out_type          rsp_count_ff, rsp_count_in;
   logic             rsp_full_ff, rsp_full_in;

   // Slot memory: bit KEY_W is the valid mark, the rest the stored key
   logic [KEY_W:0]   slot_mem [TABLE_DEPTH];
   logic             rd_valid_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [KEY_W:0]   mem_wdata;
   logic [IDX_W-1:0] mem_raddr;

   logic             div_start;
   logic             div_done;
   size_type         div_rem;

   size_type         size_eff;
   size_type         probe_nxt;
   size_type         skip_nxt;
   logic             out_free;
   logic             req_xfer;

   lphi_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_chan.key),
      .divisor   (size_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Size as used: zero reads as one, clamp to the depth
   always_comb begin
      size_eff = csr_wr_data;
      if (csr_wr_data == '0) begin
         size_eff = SIZE_W'(1);
      end else if (32'(csr_wr_data) > TABLE_DEPTH) begin
         size_eff = SIZE_W'(TABLE_DEPTH);
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign div_start      = req_xfer;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign skip_nxt       = skip_ff + SIZE_W'(1);
   assign probe_nxt      = (probe_ff + SIZE_W'(1) == size_ff) ? '0 : probe_ff + SIZE_W'(1);
   assign mem_raddr      = IDX_W'(probe_ff);

   // Control sequence and probe walk
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      clr_in       = clr_ff;
      key_in       = key_ff;
      probe_in     = probe_ff;
      skip_in      = skip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_count_in = rsp_count_ff;
      rsp_full_in  = rsp_full_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               key_in   = req_chan.key;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (div_done) begin
               probe_in = div_rem;
               skip_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!rd_valid_ff) begin
               // free slot: store the key and report it
               if (out_free) begin
                  mem_we       = 1'b1;
                  mem_waddr    = IDX_W'(probe_ff);
                  mem_wdata    = {1'b1, key_ff};
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = OUT_W'(probe_ff);
                  rsp_count_in = OUT_W'(skip_ff);
                  rsp_full_in  = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else if (skip_nxt == size_ff) begin
               // every slot in use is taken
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = '0;
                  rsp_count_in = '0;
                  rsp_full_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               skip_in  = skip_nxt;
               probe_in = probe_nxt;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase

      // A size write empties the table
      if (csr_wr_en) begin
         size_in  = size_eff;
         state_in = ST_CLEAR;
         clr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         size_ff      <= SIZE_W'(SIZE_RST);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      probe_ff     <= probe_in;
      skip_ff      <= skip_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
      rsp_full_ff  <= rsp_full_in;
   end

   // Slot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_valid_ff <= slot_mem[mem_raddr][KEY_W];
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.slot_index  = rsp_slot_ff;
   assign rsp_chan.probe_count = rsp_count_ff;
   assign rsp_chan.table_full  = rsp_full_ff;

   // Checks
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (probe_ff < size_ff))
      else $error("probe index outside the table");

   a_skip_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (skip_ff < size_ff))
      else $error("probe count reached the table size");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> (rsp_slot_ff == '0 && rsp_count_ff == '0))
      else $error("full result carries a slot or count");

   a_size_clears: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (state_ff == ST_CLEAR && clr_ff == '0))
      else $error("size write did not start a clearing pass");

endmodule

/* design/lphi_mod.sv */
// Remainder of a key by the table size, restoring method, DIV_BITS bits per cycle
module lphi_mod (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  lphi_pkg::key_type  dividend,
   input  lphi_pkg::size_type divisor,
   output logic               done,
   output lphi_pkg::size_type remainder
);
   import lphi_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIV_CW-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]    sh_ff, sh_in;
   size_type            rem_ff, rem_in;

   // Next remainder and shifted dividend after DIV_BITS steps, as done in each busy cycle
   logic [DIV_W-1:0]    step_sh;
   size_type            step_rem;

   always_comb begin
      logic [SIZE_W:0] trial;
      step_sh  = sh_ff;
      step_rem = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {step_rem, step_sh[DIV_W-1]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         step_rem = trial[SIZE_W-1:0];
         step_sh  = {step_sh[DIV_W-2:0], 1'b0};
      end
   end

   // Sequencing of the iterations
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = {{(DIV_W-KEY_W){1'b0}}, dividend};
         rem_in  = '0;
      end else if (busy_ff) begin
         sh_in  = step_sh;
         rem_in = step_rem;
         cnt_in = cnt_ff + DIV_CW'(1);
         if (cnt_ff == DIV_CW'(DIV_CYC - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
